// ===== rtl/dmwt_pkg.sv =====
package dmwt_pkg;

  localparam int INDEX_BITS  = 4;
  localparam int OFFSET_BITS = 2;
  localparam int ADDR_BITS   = 12;
  localparam int WORD_WIDTH  = 16;
  localparam int COUNT_WIDTH = 32;

  localparam int TAG_WIDTH   = ADDR_BITS - INDEX_BITS - OFFSET_BITS;
  localparam int NUM_LINES   = 1 << INDEX_BITS;
  localparam int LINE_SIZE   = 1 << OFFSET_BITS;
  localparam int DATA_DEPTH  = NUM_LINES * LINE_SIZE;
  localparam int STORE_DEPTH = 1 << ADDR_BITS;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [WORD_WIDTH-1:0] word_t;

  // Write port of the backing store.
  typedef struct packed {
    logic  en;
    addr_t addr;
    word_t data;
  } store_wr_t;

endpackage

// ===== rtl/direct_mapped_write_through_cache_top.sv =====
// Direct-mapped, write-through, no-write-allocate cache over a 4096-word
// backing store held inside the block.
// The input channel (in_valid, in_stall) carries op, address and write_data;
// the output channel (out_valid, out_stall) returns exactly one item per input
// item: read_data, hit and the hit and miss counts after that item.
// Items are processed one at a time. A read miss fills the line from the store
// one word per cycle through its single read port before its result goes to
// the output register; every other item goes there straight from the lookup.
// The result sits in an output register, so a new item can be accepted while
// the previous result is still stalled; the block then holds its next result
// internally until the output register frees up.
// After reset the backing store is zeroed one word per cycle, and in_stall stays
// high until that is done. Line valid bits and both counters clear at once.
module direct_mapped_write_through_cache_top
  import dmwt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             op,
  input  addr_t                  address,
  input  word_t                  write_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output word_t                  read_data,
  output logic                   hit,
  output logic [COUNT_WIDTH-1:0] hit_count,
  output logic [COUNT_WIDTH-1:0] miss_count
);

  typedef enum logic [1:0] {S_IDLE, S_LOOKUP, S_FILL, S_RESP} state_t;

  state_t                  state;
  logic [1:0]              cur_op;
  addr_t                   cur_addr;
  word_t                   cur_wdata;
  logic [NUM_LINES-1:0]    line_valid;
  logic [OFFSET_BITS:0]    fill_cnt;
  logic                    pend;
  logic [OFFSET_BITS-1:0]  pend_off;
  word_t                   rd_word;

  logic [TAG_WIDTH-1:0]    tag_mem [NUM_LINES];
  word_t                   data_mem [DATA_DEPTH];
  logic [TAG_WIDTH-1:0]    tag_q;
  word_t                   data_q;

  logic                    accept;
  logic                    out_free;
  logic                    store_busy;
  word_t                   store_q;
  store_wr_t               store_wr;
  addr_t                   store_raddr;
  addr_t                   lk_addr;
  logic [TAG_WIDTH-1:0]    cur_tag;
  logic [INDEX_BITS-1:0]   cur_index;
  logic [OFFSET_BITS-1:0]  cur_offset;
  logic                    lookup_hit;
  logic                    last_fill;
  logic                    data_we;
  logic [INDEX_BITS+OFFSET_BITS-1:0] data_waddr;
  word_t                   data_wdata;

  assign in_stall   = (state != S_IDLE) || store_busy;
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;

  assign cur_tag    = cur_addr[ADDR_BITS-1 -: TAG_WIDTH];
  assign cur_index  = cur_addr[OFFSET_BITS +: INDEX_BITS];
  assign cur_offset = cur_addr[OFFSET_BITS-1:0];

  // The lookup read is issued in the accept cycle and repeated while waiting.
  assign lk_addr    = (state == S_IDLE) ? address : cur_addr;
  assign lookup_hit = line_valid[cur_index] && (tag_q == cur_tag);
  assign last_fill  = pend && (pend_off == OFFSET_BITS'(LINE_SIZE - 1));

  assign store_wr.en   = accept && (op == OP_WRITE);
  assign store_wr.addr = address;
  assign store_wr.data = write_data;
  assign store_raddr   = {cur_addr[ADDR_BITS-1:OFFSET_BITS], fill_cnt[OFFSET_BITS-1:0]};

  dmwt_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (store_wr),
    .rd_addr (store_raddr),
    .rd_data (store_q),
    .busy    (store_busy)
  );

  always_comb begin
    data_we    = 1'b0;
    data_waddr = {cur_index, cur_offset};
    data_wdata = cur_wdata;
    if (state == S_FILL) begin
      data_we    = pend;
      data_waddr = {cur_index, pend_off};
      data_wdata = store_q;
    end else if (state == S_LOOKUP) begin
      data_we = (cur_op == OP_WRITE) && lookup_hit && out_free;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FILL && last_fill) begin
      tag_mem[cur_index] <= cur_tag;
    end
    tag_q <= tag_mem[lk_addr[OFFSET_BITS +: INDEX_BITS]];
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    data_q <= data_mem[lk_addr[INDEX_BITS+OFFSET_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      hit_count  <= '0;
      miss_count <= '0;
      line_valid <= '0;
      fill_cnt   <= '0;
      pend       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur_op    <= op;
            cur_addr  <= address;
            cur_wdata <= write_data;
            state     <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (cur_op == OP_READ && !lookup_hit) begin
            fill_cnt <= '0;
            pend     <= 1'b0;
            state    <= S_FILL;
          end else if (out_free) begin
            out_valid <= 1'b1;
            read_data <= (cur_op == OP_READ) ? data_q : '0;
            hit       <= (cur_op == OP_READ);
            if (cur_op == OP_READ) begin
              hit_count <= hit_count + COUNT_WIDTH'(1);
            end else if (cur_op == OP_CLEAR) begin
              hit_count  <= '0;
              miss_count <= '0;
            end
            state <= S_IDLE;
          end
        end
        S_FILL: begin
          // One store word is requested per cycle and written into the line the cycle after.
          if (!fill_cnt[OFFSET_BITS]) begin
            fill_cnt <= fill_cnt + (OFFSET_BITS + 1)'(1);
            pend     <= 1'b1;
            pend_off <= fill_cnt[OFFSET_BITS-1:0];
          end else begin
            pend <= 1'b0;
          end
          if (pend && pend_off == cur_offset) begin
            rd_word <= store_q;
          end
          if (last_fill) begin
            line_valid[cur_index] <= 1'b1;
            state                 <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            read_data  <= rd_word;
            hit        <= 1'b0;
            miss_count <= miss_count + COUNT_WIDTH'(1);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/dmwt_store.sv =====
module dmwt_store
  import dmwt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  store_wr_t wr,
  input  addr_t     rd_addr,
  output word_t     rd_data,
  output logic      busy
);

  word_t mem [STORE_DEPTH];
  addr_t clr_addr;

  // After reset every entry is zeroed, one per cycle, before any item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + addr_t'(1);
      if (clr_addr == addr_t'(STORE_DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sim/dmwt_checker.sv =====
module dmwt_checker
  import dmwt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [1:0]             op,
  input  addr_t                  address,
  input  word_t                  write_data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  word_t                  read_data,
  input  logic                   hit,
  input  logic [COUNT_WIDTH-1:0] hit_count,
  input  logic [COUNT_WIDTH-1:0] miss_count,
  output int                     fail_count,
  output int                     pending,
  output int                     checked,
  output int                     hits_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    word_t                  data;
    logic                   hit;
    logic [COUNT_WIDTH-1:0] hits;
    logic [COUNT_WIDTH-1:0] misses;
  } cache_reply_t;

  // Shadow copy of the cache and its backing store.
  logic                   line_live     [NUM_LINES];
  logic [TAG_WIDTH-1:0]   line_tag_copy [NUM_LINES];
  word_t                  line_copy     [DATA_DEPTH];
  word_t                  store_copy    [STORE_DEPTH];
  logic [COUNT_WIDTH-1:0] hit_tally;
  logic [COUNT_WIDTH-1:0] miss_tally;

  cache_reply_t reply_q [$];
  cache_reply_t want;
  cache_reply_t seen;

  function automatic cache_reply_t access_cache(input logic [1:0] o, input addr_t a,
                                                input word_t d);
    cache_reply_t          r;
    logic [INDEX_BITS-1:0] idx;
    logic [TAG_WIDTH-1:0]  tg;
    int                    slot;
    logic                  found;
    idx   = a[OFFSET_BITS +: INDEX_BITS];
    tg    = a[ADDR_BITS-1 -: TAG_WIDTH];
    slot  = idx * LINE_SIZE + a[OFFSET_BITS-1:0];
    found = line_live[idx] && (line_tag_copy[idx] == tg);
    r     = '0;
    case (o)
      OP_READ: begin
        if (found) begin
          r.hit     = 1'b1;
          hit_tally = hit_tally + 1'b1;
        end else begin
          miss_tally = miss_tally + 1'b1;
          for (int i = 0; i < LINE_SIZE; i++) begin
            line_copy[idx * LINE_SIZE + i] =
              store_copy[{a[ADDR_BITS-1:OFFSET_BITS], i[OFFSET_BITS-1:0]}];
          end
          line_tag_copy[idx] = tg;
          line_live[idx]     = 1'b1;
        end
        r.data = line_copy[slot];
      end
      OP_WRITE: begin
        // Write-through: the store always takes it, the line only on a hit.
        store_copy[a] = d;
        if (found) line_copy[slot] = d;
      end
      OP_CLEAR: begin
        hit_tally  = '0;
        miss_tally = '0;
      end
      default: ;
    endcase
    r.hits   = hit_tally;
    r.misses = miss_tally;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        line_live[i]     = 1'b0;
        line_tag_copy[i] = '0;
      end
      for (int i = 0; i < DATA_DEPTH; i++) line_copy[i] = '0;
      for (int i = 0; i < STORE_DEPTH; i++) store_copy[i] = '0;
      hit_tally    = '0;
      miss_tally   = '0;
      reply_q.delete();
      fail_count   = 0;
      checked      = 0;
      hits_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = '{data: read_data, hit: hit, hits: hit_count, misses: miss_count};
        if (reply_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result item with nothing expected: data %h hit %b counts %0d/%0d",
                     $realtime, read_data, hit, hit_count, miss_count);
          end
        end else begin
          want = reply_q.pop_front();
          checked++;
          if (hit) hits_checked++;
          if (seen.data !== want.data || seen.hit !== want.hit ||
              seen.hits !== want.hits || seen.misses !== want.misses) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result %0d wrong: data %h/%h hit %b/%b hits %0d/%0d misses %0d/%0d",
                       $realtime, checked, seen.data, want.data, seen.hit, want.hit,
                       seen.hits, want.hits, seen.misses, want.misses);
            end
          end
        end
      end
      if (in_valid && !in_stall) reply_q.push_back(access_cache(op, address, write_data));
    end
    pending = reply_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import dmwt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         HOLD_CYCLES = 300;
  localparam int         RANDOM_ITEMS = 720;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             op;
  addr_t                  address;
  word_t                  write_data;
  logic                   out_valid;
  logic                   out_stall;
  word_t                  read_data;
  logic                   hit;
  logic [COUNT_WIDTH-1:0] hit_count;
  logic [COUNT_WIDTH-1:0] miss_count;

  int fail_count;
  int pending;
  int checked;
  int hits_checked;
  int sent_count;
  bit quiet_phase;
  bit hold_done;

  direct_mapped_write_through_cache_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .address    (address),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .hit        (hit),
    .hit_count  (hit_count),
    .miss_count (miss_count)
  );

  dmwt_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .address      (address),
    .write_data   (write_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_data    (read_data),
    .hit          (hit),
    .hit_count    (hit_count),
    .miss_count   (miss_count),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .hits_checked (hits_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one item, with random idle cycles ahead of it outside the quiet phase,
  // and returns right after the edge that accepted it.
  task automatic send_item(input logic [1:0] o, input addr_t a, input word_t d);
    if (!quiet_phase) begin
      while ($urandom_range(0, 99) < 37) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    op         <= o;
    address    <= a;
    write_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // Half the time one of three tags per line so that reads hit and lines get
  // evicted, a quarter the same line as the previous item, else anywhere.
  function automatic addr_t pick_address(input addr_t prev);
    case ($urandom_range(0, 3))
      0, 1: return {TAG_WIDTH'($urandom_range(0, 2)), INDEX_BITS'($urandom),
                    OFFSET_BITS'($urandom)};
      2: return {prev[ADDR_BITS-1:OFFSET_BITS], OFFSET_BITS'($urandom)};
      default: return addr_t'($urandom);
    endcase
  endfunction

  initial begin
    addr_t last_addr;
    addr_t a;
    int    pick;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    op          <= OP_READ;
    address     <= '0;
    write_data  <= '0;
    quiet_phase = 1'b0;
    sent_count  = 0;
    last_addr   = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: cold miss, hit, write hit, write miss without allocate,
    // eviction by another tag, clear, the unused op and the address extremes.
    send_item(OP_READ,   12'h000, 16'h0000);
    send_item(OP_READ,   12'h000, 16'hFFFF);
    send_item(OP_WRITE,  12'h000, 16'hFFFF);
    send_item(OP_READ,   12'h000, 16'h0000);
    send_item(OP_WRITE,  12'hFFF, 16'hFFFF);
    send_item(OP_READ,   12'hFFF, 16'h0000);
    send_item(OP_READ,   12'hFFC, 16'h0000);
    send_item(OP_WRITE,  12'h040, 16'h1234);
    send_item(OP_READ,   12'h040, 16'h0000);
    send_item(OP_READ,   12'h000, 16'h0000);
    send_item(OP_WRITE,  12'h001, 16'h0000);
    send_item(OP_CLEAR,  12'hFFF, 16'hFFFF);
    send_item(OP_UNUSED, 12'hFFF, 16'hFFFF);
    send_item(OP_READ,   12'h001, 16'h0000);
    send_item(OP_WRITE,  12'hAAA, 16'h5555);
    send_item(OP_READ,   12'hAAA, 16'h0000);
    send_item(OP_WRITE,  12'h555, 16'hAAAA);
    send_item(OP_READ,   12'h555, 16'hFFFF);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // A stretch in the middle runs with neither side idling.
      quiet_phase = (n >= 350 && n < 500);
      a    = pick_address(last_addr);
      pick = $urandom_range(0, 99);
      if (pick < 52) begin
        send_item(OP_READ, a, word_t'($urandom));
      end else if (pick < 82) begin
        send_item(OP_WRITE, a, word_t'($urandom));
      end else if (pick < 92) begin
        send_item(OP_WRITE, a, word_t'($urandom));
        send_item(OP_READ, a, word_t'($urandom));
      end else if (pick < 96) begin
        send_item(OP_CLEAR, a, word_t'($urandom));
      end else begin
        send_item(OP_UNUSED, a, word_t'($urandom));
      end
      last_addr = a;
    end
    quiet_phase = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d items of all four op codes, checked %0d results, %0d of them read hits.",
             sent_count, checked, hits_checked);
    $display("The output was held off for %0d cycles once while items kept coming.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("direct_mapped_write_through_cache_top: match");
    end else begin
      $display("direct_mapped_write_through_cache_top: mismatch");
    end
    $finish;
  end

  // Receiver: random stalls, none during the quiet stretch, and one long
  // hold-off so that the block backs up into its input.
  initial begin
    out_stall <= 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sent_count >= 250) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end else if (quiet_phase) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 37);
      end
    end
  end

  // The store clear after reset and the slowest traffic fit many times over.
  initial begin
    #5_000_000;
    $display("direct_mapped_write_through_cache_top: mismatch");
    $finish;
  end

endmodule
